FILE: hdl/cmas_pkg.sv
package cmas_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_HALF_WIDTH = 15;
  localparam int DEF_SAMPLE_BITS    = 24;

  // The window setting register is a fixed 5-bit field.
  localparam int              WP_BITS  = 5;
  localparam logic [WP_BITS-1:0] WP_RESET = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SUM,
    ST_DIV,
    ST_LOAD
  } cmas_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic setup;
    logic sum;
    logic div_init;
    logic div_step;
    logic load;
  } cmas_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic emit_now;
    logic more_after;
    logic sum_done;
    logic div_done;
    logic out_free;
  } cmas_sts_t;

endpackage

FILE: hdl/cmas_ctrl.sv
module cmas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmas_pkg::cmas_sts_t sts,
  output cmas_pkg::cmas_cmd_t cmd
);
  import cmas_pkg::*;

  cmas_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.emit_now) begin
          cmd.setup = 1'b1;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = sts.more_after ? ST_DECIDE : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/cmas_datapath.sv
module cmas_datapath #(
  parameter int MAX_HALF_WIDTH = 15,
  parameter int SAMPLE_BITS    = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmas_pkg::cmas_cmd_t          cmd,
  output cmas_pkg::cmas_sts_t          sts,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic                         in_last,
  input  logic [cmas_pkg::WP_BITS-1:0] window_points,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SAMPLE_BITS-1:0]       out_smoothed,
  output logic                         out_run_last,
  output logic                         out_set_done
);
  import cmas_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 2;
  localparam int AW   = $clog2(RING_DEPTH);
  localparam int PW   = $clog2(MAX_HALF_WIDTH + 2);
  localparam int HW   = $clog2(MAX_HALF_WIDTH + 1);
  localparam int LW   = $clog2(2 * MAX_HALF_WIDTH + 2);
  localparam int SUMW = SAMPLE_BITS + $clog2(2 * MAX_HALF_WIDTH + 1);
  localparam int NW   = SUMW + 1;
  localparam int DVW  = HW + 2;
  localparam int CW   = $clog2(NW + 1);

  // Sample store and set bookkeeping.
  logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [AW-1:0] write_pos_r;
  logic [AW-1:0] newest_r;
  logic [PW-1:0] pending_r;
  logic [HW-1:0] sat_r;
  logic          last_r;

  // Window sum.
  logic [AW-1:0]                 rd_addr_r;
  logic [LW-1:0]                 rd_left_r;
  logic                          rd_vld_r;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SUMW-1:0]        acc_r;
  logic [HW-1:0]                 h_r;

  // Restoring divider; the quotient shifts into num_r.
  logic [NW-1:0]  num_r;
  logic [DVW-1:0] divisor_r;
  logic [DVW-1:0] rem_r;
  logic [CW-1:0]  cnt_r;
  logic           neg_r;

  // Output register.
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic                   out_run_last_r;
  logic                   out_set_done_r;

  logic [HW-1:0]   p_eff;
  logic [HW-1:0]   h_now;
  logic            emit_now;
  logic [PW-1:0]   pending_after;
  logic [HW-1:0]   sat_after;
  logic            more_after;
  logic [AW:0]     span;
  logic [AW:0]     start_raw;
  logic [AW-1:0]   start_addr;
  logic [SUMW-1:0] mag;
  logic [DVW:0]    rem_sh;
  logic            q_bit;
  logic [NW-1:0]   q_signed;

  function automatic logic [HW-1:0] hmin(input logic [HW-1:0] a, input logic [HW-1:0] b);
    hmin = (a < b) ? a : b;
  endfunction

  // A result is owed when the oldest pending sample has its full window,
  // or at the end of a set whenever anything is still pending.
  function automatic logic can_emit(input logic [PW-1:0] pnd, input logic [HW-1:0] sat,
                                    input logic [HW-1:0] pv, input logic lst);
    logic [HW-1:0] hm;
    hm = hmin(sat, pv);
    can_emit = (pnd != '0) && (lst || (32'(pnd) >= 32'(hm) + 1));
  endfunction

  always_comb begin
    if (32'(window_points[WP_BITS-1:1]) > MAX_HALF_WIDTH) begin
      p_eff = HW'(MAX_HALF_WIDTH);
    end else begin
      p_eff = HW'(window_points[WP_BITS-1:1]);
    end
  end

  always_comb begin
    h_now = hmin(sat_r, p_eff);
    if (last_r && pending_r != '0 && 32'(h_now) > 32'(pending_r) - 1) begin
      h_now = HW'(pending_r - PW'(1));
    end
    emit_now      = can_emit(pending_r, sat_r, p_eff, last_r);
    pending_after = pending_r - PW'(1);
    sat_after     = (32'(sat_r) < MAX_HALF_WIDTH) ? sat_r + HW'(1) : sat_r;
    more_after    = can_emit(pending_after, sat_after, p_eff, last_r);
  end

  // Oldest sample of the window lies (center + h) slots behind the newest one.
  always_comb begin
    span      = (AW+1)'(pending_r - PW'(1)) + (AW+1)'(h_now);
    start_raw = {1'b0, newest_r} + (AW+1)'(RING_DEPTH) - span;
    if (start_raw >= (AW+1)'(RING_DEPTH)) begin
      start_addr = AW'(start_raw - (AW+1)'(RING_DEPTH));
    end else begin
      start_addr = AW'(start_raw);
    end
  end

  always_comb begin
    mag      = acc_r[SUMW-1] ? SUMW'(-acc_r) : SUMW'(acc_r);
    rem_sh   = {rem_r, num_r[NW-1]};
    q_bit    = (rem_sh >= {1'b0, divisor_r});
    q_signed = neg_r ? -num_r : num_r;
  end

  // Ring write on accept, registered read during the sum.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[write_pos_r] <= signed'(in_sample);
    end
    if (cmd.sum && rd_left_r != '0) begin
      rd_data_r <= ring[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      pending_r   <= '0;
      sat_r       <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        write_pos_r <= (write_pos_r == AW'(RING_DEPTH - 1)) ? '0 : write_pos_r + AW'(1);
        if (32'(pending_r) < MAX_HALF_WIDTH + 1) begin
          pending_r <= pending_r + PW'(1);
        end
      end
      if (cmd.setup) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.sum) begin
        rd_vld_r <= (rd_left_r != '0);
      end
      if (cmd.div_init) begin
        cnt_r <= CW'(NW);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
        if (!more_after && last_r) begin
          pending_r <= '0;
          sat_r     <= '0;
        end else begin
          pending_r <= pending_after;
          sat_r     <= sat_after;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      newest_r <= write_pos_r;
      last_r   <= in_last;
    end
    if (cmd.setup) begin
      h_r       <= h_now;
      rd_addr_r <= start_addr;
      rd_left_r <= LW'({h_now, 1'b1});
      acc_r     <= '0;
    end else if (cmd.sum) begin
      if (rd_left_r != '0) begin
        rd_addr_r <= (rd_addr_r == AW'(RING_DEPTH - 1)) ? '0 : rd_addr_r + AW'(1);
        rd_left_r <= rd_left_r - LW'(1);
      end
      if (rd_vld_r) begin
        acc_r <= acc_r + SUMW'(rd_data_r);
      end
    end
    // Round to nearest, ties away: floor((2|s| + d) / 2d) with d = 2h + 1.
    if (cmd.div_init) begin
      num_r     <= {mag, 1'b0} + NW'({h_r, 1'b1});
      divisor_r <= {h_r, 1'b1, 1'b0};
      rem_r     <= '0;
      neg_r     <= acc_r[SUMW-1];
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? DVW'(rem_sh - {1'b0, divisor_r}) : DVW'(rem_sh);
      num_r <= {num_r[NW-2:0], q_bit};
    end
    if (cmd.load) begin
      out_data_r     <= q_signed[SAMPLE_BITS-1:0];
      out_run_last_r <= !more_after;
      out_set_done_r <= !more_after && last_r;
    end
  end

  assign sts.emit_now   = emit_now;
  assign sts.more_after = more_after;
  assign sts.sum_done   = (rd_left_r == '0) && !rd_vld_r;
  assign sts.div_done   = (cnt_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_smoothed = out_data_r;
  assign out_run_last = out_run_last_r;
  assign out_set_done = out_set_done_r;

endmodule

FILE: hdl/centered_moving_average_smoother.sv
// Centered moving-average smoother for signed fixed-point data sets.
// Input stream: in_tdata carries one sample, in_tlast marks the final sample
// of a set. Output stream: out_tdata carries the window mean, out_tlast marks
// the last word caused by one input word, and out_tuser flags the final word
// of the whole set. cfg_data sets the window length; half width is half of
// it, capped at MAX_HALF_WIDTH. Write it only while the block is idle.
// The block works on one input word at a time: it takes the word and decides.
// Each output then reads the window from the single-port sample ring and
// accumulates the window sum, runs the bit-serial divider, and decides and
// loads. The window sum is SUMW = SAMPLE_BITS + clog2(2 * MAX_HALF_WIDTH + 1)
// bits wide. An output register parts the two streams, so the next input
// word is taken while a result still waits; a stalled receiver holds the
// block only when a further result is ready to load. Synchronous reset
// clears the set state and the output valid; the ring needs no clearing.
module centered_moving_average_smoother #(
  parameter int MAX_HALF_WIDTH = cmas_pkg::DEF_MAX_HALF_WIDTH,
  parameter int SAMPLE_BITS    = cmas_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Input stream; tdata fields from bit 0: sample, zero pad.
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                                     in_tlast,
  // Result stream; tdata fields from bit 0: smoothed, zero pad.
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                     out_tlast,
  // tuser fields from bit 0: set_done.
  output logic [0:0]                               out_tuser,
  // Window setting write channel.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [cmas_pkg::WP_BITS-1:0]             cfg_data
);
  import cmas_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [WP_BITS-1:0]     window_points_r;
  cmas_cmd_t              cmd;
  cmas_sts_t              sts;
  logic [SAMPLE_BITS-1:0] smoothed;
  logic                   set_done;

  // The window register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_points_r <= WP_RESET;
    end else if (cfg_valid) begin
      window_points_r <= cfg_data;
    end
  end

  cmas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cmas_datapath #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (in_tdata[SAMPLE_BITS-1:0]),
    .in_last       (in_tlast),
    .window_points (window_points_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_smoothed  (smoothed),
    .out_run_last  (out_tlast),
    .out_set_done  (set_done)
  );

  // Zero-extend the mean to whole bytes.
  assign out_tdata = TDATA_W'(smoothed);
  assign out_tuser = set_done;

endmodule

FILE: hdl/cmas_checker.sv
module cmas_checker #(
  parameter int TDATA_W = 24
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast,
  input logic [0:0]         out_tuser
);

  // A held result word keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The end of a set is always also the end of the current run.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("set done without run last");

  // One word in work at a time: input is closed in the cycle after a take.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

endmodule

bind centered_moving_average_smoother cmas_checker #(
  .TDATA_W (TDATA_W)
) u_cmas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

FILE: dv/tb_centered_moving_average_smoother.sv
`timescale 1ns / 1ps

module tb_centered_moving_average_smoother;
  import cmas_pkg::*;

  localparam int HALF_MAX = DEF_MAX_HALF_WIDTH;
  localparam int SBITS    = DEF_SAMPLE_BITS;
  localparam int DBITS    = ((SBITS + 7) / 8) * 8;
  // The window can reach 2*HALF_MAX samples behind the newest one, so the
  // shadow ring keeps two more slots than that, like the block does.
  localparam int RING_LEN = 2 * HALF_MAX + 2;
  localparam int STEP_MAX = HALF_MAX + 1;
  // Settling time covers the last output inside the block, and a word that makes
  // no output still has to be taken and decided.
  localparam int SETTLE   = 200;
  localparam int HOLD_LEN = 3000;
  localparam int LIMIT    = 400000;

  typedef struct {
    logic [SBITS-1:0] sample;
    logic             last;
  } sample_word_t;

  typedef struct {
    logic [SBITS-1:0] smoothed;
    logic             run_last;
    logic             set_done;
  } mean_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // in_tdata fields from bit 0: sample.
  logic [DBITS-1:0]   in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // out_tdata fields from bit 0: smoothed.
  logic [DBITS-1:0]   out_tdata;
  logic               out_tlast;
  // out_tuser fields from bit 0: set_done.
  logic [0:0]         out_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [WP_BITS-1:0] cfg_data = '0;

  // Words waiting to be offered, and the window means still owed by the block.
  sample_word_t sample_words[$];
  mean_word_t   expected_means[$];
  sample_word_t next_word;
  mean_word_t   seen_mean;
  mean_word_t   want_mean;

  // Idling knobs; the stimulus process changes them only at a falling edge.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int errors = 0;
  int cycle_count = 0;

  // Shadow state of the smoother: the sample history, how many outputs of the
  // current set are still owed, and how many were emitted so far (saturating
  // at HALF_MAX, which is all the half width rule ever needs).
  logic signed [SBITS-1:0] ring_mem [RING_LEN];
  int unsigned             ring_wr = 0;
  int unsigned             owed = 0;
  int unsigned             emitted = 0;
  logic [WP_BITS-1:0]      window_setting = WP_RESET;

  centered_moving_average_smoother u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Mean of the window of half width h around the oldest owed sample. The
  // divisor is odd, so rounding to nearest never meets an exact tie; the
  // magnitude is rounded and the sign put back, which is ties away from zero.
  function automatic logic [SBITS-1:0] window_mean(int unsigned h);
    int unsigned      center;
    int unsigned      k;
    int unsigned      slot;
    longint           sum;
    longint unsigned  mag;
    longint unsigned  div;
    longint unsigned  quo;
    longint           mean;
    center = owed - 1;
    sum = 0;
    div = 2 * h + 1;
    for (k = center - h; k <= center + h; k++) begin
      slot = (ring_wr + RING_LEN - 1 - k) % RING_LEN;
      sum += ring_mem[slot];
    end
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    quo = (2 * mag + div) / (2 * div);
    mean = (sum < 0) ? -longint'(quo) : longint'(quo);
    return mean[SBITS-1:0];
  endfunction

  // Takes one accepted sample and queues every mean that it makes ready.
  // Output i needs sample i+h; the word that closes the set flushes the rest
  // with the half width clipped to the samples that remain on the right.
  function automatic void advance_smoother(logic [SBITS-1:0] sample, logic last);
    int unsigned half;
    int unsigned h;
    int unsigned n;
    mean_word_t  w;
    half = window_setting >> 1;
    if (half > HALF_MAX) half = HALF_MAX;
    ring_mem[ring_wr] = sample;
    ring_wr = (ring_wr + 1) % RING_LEN;
    if (owed < STEP_MAX) owed++;
    n = 0;
    while (n < STEP_MAX && owed > 0) begin
      h = (emitted < half) ? emitted : half;
      if (last) begin
        if (h > owed - 1) h = owed - 1;
      end else if (owed < h + 1) begin
        break;
      end
      w.smoothed = window_mean(h);
      w.run_last = 1'b0;
      w.set_done = 1'b0;
      expected_means.push_back(w);
      owed--;
      if (emitted < HALF_MAX) emitted++;
      n++;
    end
    if (last) begin
      owed = 0;
      emitted = 0;
    end
    // The final word of this step carries the step marker, and the set
    // marker too when the step closed the set.
    if (n > 0) begin
      w = expected_means.pop_back();
      w.run_last = 1'b1;
      w.set_done = last;
      expected_means.push_back(w);
    end
  endfunction

  // Sender. The smoother is stepped at the edge where a word is taken; a new
  // word is put up only when the bus is free, so in_tvalid gets one update.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_smoother(in_tdata[SBITS-1:0], in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (sample_words.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_word = sample_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= DBITS'(next_word.sample);
          in_tlast <= next_word.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every word taken is checked field by field against the oldest
  // owed mean; the ready line stalls at random or for the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_mean.smoothed = out_tdata[SBITS-1:0];
        seen_mean.run_last = out_tlast;
        seen_mean.set_done = out_tuser[0];
        if (expected_means.size() == 0) begin
          $error("unexpected result word: smoothed %0d", $signed(seen_mean.smoothed));
          errors++;
        end else begin
          want_mean = expected_means.pop_front();
          if (seen_mean.smoothed !== want_mean.smoothed) begin
            $error("smoothed mismatch: expected %0d, got %0d",
                   $signed(want_mean.smoothed), $signed(seen_mean.smoothed));
            errors++;
          end
          if (seen_mean.run_last !== want_mean.run_last) begin
            $error("run_last mismatch: expected %0b, got %0b",
                   want_mean.run_last, seen_mean.run_last);
            errors++;
          end
          if (seen_mean.set_done !== want_mean.set_done) begin
            $error("set_done mismatch: expected %0b, got %0b",
                   want_mean.set_done, seen_mean.set_done);
            errors++;
          end
        end
      end
      out_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the output register
  // fills, the block runs out of room and has to stall its input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_word(input logic [SBITS-1:0] sample, input logic last);
    sample_word_t w;
    w.sample = sample;
    w.last = last;
    sample_words.push_back(w);
  endtask

  // Queues a data set of len samples. Values mix the two extremes, small
  // numbers of either sign (so rounding shows) and full-range noise.
  task automatic add_set(input int len, input logic close_set);
    int               i;
    logic [SBITS-1:0] s;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: s = {1'b0, {(SBITS - 1){1'b1}}};
        1: s = {1'b1, {(SBITS - 1){1'b0}}};
        2, 3, 4: s = SBITS'($urandom_range(0, 400)) - SBITS'(200);
        default: s = SBITS'($urandom());
      endcase
      add_word(s, close_set && (i == len - 1));
    end
  endtask

  // Waits until every word went in and every owed mean came out, then gives
  // the block time to finish a word that makes no output.
  task automatic drain(input int settle);
    do @(negedge clk);
    while (sample_words.size() != 0 || in_tvalid || expected_means.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Window setting write; only called while the block is idle.
  task automatic write_window(input logic [WP_BITS-1:0] wp);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= wp;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_setting = wp;
  endtask

  // One random phase: a window setting, an idling mix and whole data sets,
  // mostly short with now and then a longer one.
  task automatic run_phase(input int tx_pct, input int rx_pct,
                           input logic [WP_BITS-1:0] wp, input int n_words,
                           input logic squeeze);
    int added;
    int len;
    write_window(wp);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (squeeze) hold_go = 1'b1;
    added = 0;
    while (added < n_words) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 70) : $urandom_range(1, 40);
      add_set(len, 1'b1);
      added += len;
    end
    drain(SETTLE);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window setting: single-sample sets at both extremes pass through
    // unchanged, then a short set with extremes and small values of either sign.
    add_word({1'b0, {(SBITS - 1){1'b1}}}, 1'b1);
    add_word({1'b1, {(SBITS - 1){1'b0}}}, 1'b1);
    add_word({1'b0, {(SBITS - 1){1'b1}}}, 1'b0);
    add_word({1'b0, {(SBITS - 1){1'b1}}}, 1'b0);
    add_word({1'b1, {(SBITS - 1){1'b0}}}, 1'b0);
    add_word({1'b1, {(SBITS - 1){1'b0}}}, 1'b0);
    add_word(-SBITS'(2), 1'b0);
    add_word(SBITS'(1), 1'b1);
    drain(SETTLE);

    // Widest window, then a set left open: with the half width cut to zero
    // in the middle, the next word releases every mean still owed at once.
    write_window(5'd31);
    @(negedge clk);
    add_set(18, 1'b0);
    drain(SETTLE);
    write_window(5'd1);
    @(negedge clk);
    add_set(2, 1'b1);
    drain(SETTLE);

    run_phase(0, 0, 5'd0, 70, 1'b1);
    run_phase(64, 0, WP_BITS'($urandom_range(2, 30)), 70, 1'b0);
    run_phase(0, 64, 5'd31, 70, 1'b0);
    run_phase(30, 30, WP_BITS'($urandom_range(0, 31)), 70, 1'b0);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
